// ----- rtl/tcti_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcti_pkg: shared constants and types
// Widths of the threshold crossing time picker and its divider.
// ----------------------------------------------------------------------------
package tcti_pkg;

	localparam int RECORD_LENGTH = 2048;
	localparam int FRAC_BITS     = 8;

	localparam int SAMPLE_W = 16;
	localparam int TIME_W   = 20;
	localparam int IDX_W    = $clog2(RECORD_LENGTH);
	// |level - prev| < 2^16, so the scaled numerator magnitude fits 16+FRAC_BITS bits
	localparam int DEN_W    = SAMPLE_W;
	localparam int MAG_W    = SAMPLE_W + FRAC_BITS;
	localparam int DCNT_W   = $clog2(MAG_W + 1);
	localparam int SUM_W    = (SAMPLE_W + 2 + FRAC_BITS > TIME_W + 1) ?
	                          (SAMPLE_W + 2 + FRAC_BITS) : (TIME_W + 1);

	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;
	localparam logic [PADDR_W-3:0] REG_LEVEL = '0;

	localparam logic signed [TIME_W-1:0] TIME_MAX = {1'b0, {(TIME_W-1){1'b1}}};
	localparam logic signed [TIME_W-1:0] TIME_MIN = {1'b1, {(TIME_W-1){1'b0}}};

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_DIV  = 3'b010,
		S_FIN  = 3'b100
	} seq_state_t;

endpackage

// ----- rtl/tcti_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcti_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle, MAG_W quotient bits per divide.
// ----------------------------------------------------------------------------
module tcti_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [tcti_pkg::MAG_W-1:0]  dividend,
	input  logic [tcti_pkg::DEN_W-1:0]  divisor,
	output logic [tcti_pkg::MAG_W-1:0]  quotient,
	output tcti_pkg::div_stat_t         stat
);

	logic [tcti_pkg::DEN_W-1:0]  rem_q;
	logic [tcti_pkg::MAG_W-1:0]  quot_q;
	logic [tcti_pkg::DEN_W-1:0]  den_q;
	logic [tcti_pkg::DCNT_W-1:0] cnt_q;
	logic                        busy_q;
	logic                        done_q;

	logic [tcti_pkg::DEN_W:0] rem_sh;
	logic [tcti_pkg::DEN_W:0] rem_diff;
	logic                     ge;

	assign rem_sh   = {rem_q, quot_q[tcti_pkg::MAG_W-1]};
	assign rem_diff = rem_sh - {1'b0, den_q};
	assign ge       = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == tcti_pkg::DCNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= tcti_pkg::DCNT_W'(tcti_pkg::MAG_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == tcti_pkg::DCNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quot_q <= dividend;
			den_q  <= divisor;
		end else if (busy_q) begin
			rem_q  <= ge ? rem_diff[tcti_pkg::DEN_W-1:0] : rem_sh[tcti_pkg::DEN_W-1:0];
			quot_q <= {quot_q[tcti_pkg::MAG_W-2:0], ge};
		end
	end

	assign quotient  = quot_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !start) else $error("divider restarted while busy");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q)) else $error("divider done without a divide");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("divider done held");

endmodule

// ----- rtl/threshold_crossing_time_interp_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// threshold_crossing_time_interp_top: leading-edge time pick
// Finds the first threshold crossing of a sample record and interpolates
// its time between the two neighbouring samples.
// ----------------------------------------------------------------------------
// Samples are taken one word per cycle while in_stall is low. The crossing
// sample (at most one per record) holds in_stall high while the radix-2
// divider works out the interpolation fraction, MAG_W (16+FRAC_BITS, 24 by
// default) quotient bits wide, in S_DIV and then S_FIN, or in S_FIN alone
// when the crossing samples are equal. crossing_time is the index of the
// sample before the crossing times 2^FRAC_BITS plus the signed fraction,
// saturated to 20 bits; a record without a crossing gives one word with
// crossing_found low and time zero. crossing_level is at APB byte address 0.
// ----------------------------------------------------------------------------
module threshold_crossing_time_interp_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [tcti_pkg::PADDR_W-1:0]          paddr,
	input  logic [tcti_pkg::PDATA_W-1:0]          pwdata,
	output logic [tcti_pkg::PDATA_W-1:0]          prdata,
	output logic                                  pready,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [tcti_pkg::SAMPLE_W-1:0]  sample_value,
	input  logic                                  record_end,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [tcti_pkg::TIME_W-1:0]    crossing_time,
	output logic                                  crossing_found
);

	logic signed [tcti_pkg::SAMPLE_W-1:0] level_q;
	logic signed [tcti_pkg::SAMPLE_W-1:0] prev_q;
	logic [tcti_pkg::IDX_W-1:0]           idx_q;
	logic                                 done_q;
	tcti_pkg::seq_state_t                 state_q;

	logic [tcti_pkg::IDX_W-1:0]           idx_m1_q;
	logic                                 neg_q;
	logic                                 den_zero_q;

	logic                                 out_valid_q;
	logic signed [tcti_pkg::TIME_W-1:0]   out_time_q;
	logic                                 out_found_q;

	// config port
	logic cfg_wr;
	logic level_sel;

	assign pready    = 1'b1;
	assign level_sel = paddr[tcti_pkg::PADDR_W-1:2] == tcti_pkg::REG_LEVEL;
	assign cfg_wr    = psel && penable && pwrite && level_sel;
	assign prdata    = level_sel ? tcti_pkg::PDATA_W'(level_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
		end else if (cfg_wr) begin
			level_q <= pwdata[tcti_pkg::SAMPLE_W-1:0];
		end
	end

	// input side
	logic in_acc;
	logic hit;
	logic signed [tcti_pkg::SAMPLE_W:0] num_d;
	logic signed [tcti_pkg::SAMPLE_W:0] den_d;
	logic [tcti_pkg::SAMPLE_W:0]        num_abs;
	logic [tcti_pkg::SAMPLE_W:0]        den_abs;
	logic [tcti_pkg::MAG_W-1:0]         dividend;
	logic                               div_start;
	logic [tcti_pkg::MAG_W-1:0]         quotient;
	tcti_pkg::div_stat_t                div_stat;

	assign in_stall = (state_q != tcti_pkg::S_IDLE) || (out_valid_q && out_stall);
	assign in_acc   = in_valid && !in_stall;
	assign hit      = !done_q && (idx_q != '0) && (sample_value >= level_q);

	assign num_d    = {level_q[tcti_pkg::SAMPLE_W-1], level_q} -
	                  {prev_q[tcti_pkg::SAMPLE_W-1], prev_q};
	assign den_d    = {sample_value[tcti_pkg::SAMPLE_W-1], sample_value} -
	                  {prev_q[tcti_pkg::SAMPLE_W-1], prev_q};
	assign num_abs  = num_d[tcti_pkg::SAMPLE_W] ? -num_d : num_d;
	assign den_abs  = den_d[tcti_pkg::SAMPLE_W] ? -den_d : den_d;
	assign dividend = tcti_pkg::MAG_W'(num_abs[tcti_pkg::SAMPLE_W-1:0]) << tcti_pkg::FRAC_BITS;
	assign div_start = in_acc && hit && (den_d != '0);

	tcti_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (den_abs[tcti_pkg::DEN_W-1:0]),
		.quotient (quotient),
		.stat     (div_stat)
	);

	// final time: (idx-1)*2^F + signed fraction, then saturate
	logic signed [tcti_pkg::SUM_W-1:0] q_ext;
	logic signed [tcti_pkg::SUM_W-1:0] q_sgn;
	logic signed [tcti_pkg::SUM_W-1:0] base;
	logic signed [tcti_pkg::SUM_W-1:0] t_sum;
	logic signed [tcti_pkg::TIME_W-1:0] t_sat;

	assign q_ext = den_zero_q ? '0 : tcti_pkg::SUM_W'(quotient);
	assign q_sgn = neg_q ? -q_ext : q_ext;
	assign base  = tcti_pkg::SUM_W'(idx_m1_q) << tcti_pkg::FRAC_BITS;
	assign t_sum = base + q_sgn;

	always_comb begin
		if (t_sum > tcti_pkg::SUM_W'(tcti_pkg::TIME_MAX)) begin
			t_sat = tcti_pkg::TIME_MAX;
		end else if (t_sum < tcti_pkg::SUM_W'(tcti_pkg::TIME_MIN)) begin
			t_sat = tcti_pkg::TIME_MIN;
		end else begin
			t_sat = t_sum[tcti_pkg::TIME_W-1:0];
		end
	end

	// a new output word: finished pick, or a record that ended without one
	logic out_load;

	assign out_load = (state_q == tcti_pkg::S_FIN) ||
	                  (in_acc && !hit && record_end && !done_q);

	// sequencer and record state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tcti_pkg::S_IDLE;
			prev_q      <= '0;
			idx_q       <= '0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				tcti_pkg::S_IDLE: begin
					if (in_acc) begin
						if (hit) begin
							state_q <= (den_d != '0) ? tcti_pkg::S_DIV : tcti_pkg::S_FIN;
						end
						if (record_end) begin
							prev_q <= '0;
							idx_q  <= '0;
							done_q <= 1'b0;
						end else begin
							prev_q <= sample_value;
							if (idx_q != tcti_pkg::IDX_W'(tcti_pkg::RECORD_LENGTH - 1)) begin
								idx_q <= idx_q + 1'b1;
							end
							if (hit) begin
								done_q <= 1'b1;
							end
						end
					end
				end
				tcti_pkg::S_DIV: begin
					if (div_stat.done) begin
						state_q <= tcti_pkg::S_FIN;
					end
				end
				tcti_pkg::S_FIN: begin
					state_q <= tcti_pkg::S_IDLE;
				end
				default: begin
					state_q <= tcti_pkg::S_IDLE;
				end
			endcase
		end
	end

	// crossing context and output word
	always_ff @(posedge clk) begin
		if (in_acc && hit) begin
			idx_m1_q   <= idx_q - 1'b1;
			neg_q      <= num_d[tcti_pkg::SAMPLE_W] ^ den_d[tcti_pkg::SAMPLE_W];
			den_zero_q <= den_d == '0;
		end
		if (state_q == tcti_pkg::S_FIN) begin
			out_time_q  <= t_sat;
			out_found_q <= 1'b1;
		end else if (in_acc && !hit && record_end && !done_q) begin
			out_time_q  <= '0;
			out_found_q <= 1'b0;
		end
	end

	assign out_valid      = out_valid_q;
	assign crossing_time  = out_time_q;
	assign crossing_found = out_found_q;

	a_acc_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> state_q == tcti_pkg::S_IDLE) else $error("word taken while busy");
	a_div_to_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tcti_pkg::S_DIV && div_stat.done) |=> state_q == tcti_pkg::S_FIN)
		else $error("divide result dropped");
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tcti_pkg::S_FIN |-> !out_valid_q) else $error("output word overwritten");
	a_div_only_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.busy |-> state_q == tcti_pkg::S_DIV) else $error("divider busy out of sequence");

endmodule
